FILE: hw/rtl/ntprp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntprp_pkg
// Types and constants shared by the NTP request/reply pairing unit.
// ----------------------------------------------------------------------------
package ntprp_pkg;

    localparam int ADDR_W   = 64;
    localparam int PORT_W   = 16;
    localparam int STAMP_W  = 64;
    localparam int RECORD_W = 48;
    localparam int V4_W     = 32;

    localparam logic [PORT_W-1:0] SERVER_PORT_RST = 16'd123;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_STORE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic                ipv6;
        logic [ADDR_W-1:0]   src_hi;
        logic [ADDR_W-1:0]   src_lo;
        logic [ADDR_W-1:0]   dst_hi;
        logic [ADDR_W-1:0]   dst_lo;
        logic [PORT_W-1:0]   udp_src;
        logic [PORT_W-1:0]   udp_dst;
        logic [STAMP_W-1:0]  key;
        logic [RECORD_W-1:0] record;
    } t_entry;

    typedef struct packed {
        logic load;
        logic scan;
        logic store;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic miss;
        logic out_free;
    } t_status;

endpackage

FILE: hw/rtl/ntprp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntprp_ctrl
// Sequencer: accept a word, scan the ring, store on miss, hand off result.
// ----------------------------------------------------------------------------
module ntprp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  ntprp_pkg::t_status i_status,
    output logic               o_in_stall,
    output ntprp_pkg::t_cmd    o_cmd
);

    ntprp_pkg::t_state r_state;
    ntprp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ntprp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ntprp_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ntprp_pkg::ST_SCAN;
                end
            end
            ntprp_pkg::ST_SCAN: begin
                if (i_status.hit) begin
                    n_state = ntprp_pkg::ST_FINISH;
                end else if (i_status.miss) begin
                    n_state = ntprp_pkg::ST_STORE;
                end
            end
            ntprp_pkg::ST_STORE: begin
                n_state = ntprp_pkg::ST_FINISH;
            end
            ntprp_pkg::ST_FINISH: begin
                if (i_status.out_free) begin
                    n_state = ntprp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ntprp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ntprp_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ntprp_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            ntprp_pkg::ST_STORE: begin
                o_cmd.store = 1'b1;
            end
            ntprp_pkg::ST_FINISH: begin
                o_cmd.finish = i_status.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

FILE: hw/rtl/ntprp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntprp_dp
// Datapath: word capture, ring memory, backward scan compare, result register.
// ----------------------------------------------------------------------------
module ntprp_dp #(
    parameter int RING_DEPTH = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ntprp_pkg::t_cmd                     i_cmd,
    output ntprp_pkg::t_status                  o_status,
    input  logic                                i_cfg_we,
    input  logic [ntprp_pkg::PORT_W-1:0]        i_cfg_data,
    input  logic                                i_is_ipv6,
    input  logic [ntprp_pkg::ADDR_W-1:0]        i_src_addr_hi,
    input  logic [ntprp_pkg::ADDR_W-1:0]        i_src_addr_lo,
    input  logic [ntprp_pkg::ADDR_W-1:0]        i_dst_addr_hi,
    input  logic [ntprp_pkg::ADDR_W-1:0]        i_dst_addr_lo,
    input  logic [ntprp_pkg::PORT_W-1:0]        i_udp_src,
    input  logic [ntprp_pkg::PORT_W-1:0]        i_udp_dst,
    input  logic [ntprp_pkg::STAMP_W-1:0]       i_transmit_stamp,
    input  logic [ntprp_pkg::STAMP_W-1:0]       i_originate_stamp,
    input  logic [ntprp_pkg::RECORD_W-1:0]      i_record_id,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic                                o_is_request,
    output logic                                o_paired,
    output logic [ntprp_pkg::RECORD_W-1:0]      o_partner_record_id
);

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);

    ntprp_pkg::t_entry r_mem [RING_DEPTH];

    logic [ntprp_pkg::PORT_W-1:0]   r_server_port;
    ntprp_pkg::t_entry              r_cur;
    logic                           r_is_req;
    logic [IDX_W-1:0]               r_wr_idx;
    logic [CNT_W-1:0]               r_fill;
    logic [IDX_W-1:0]               r_addr;
    logic [CNT_W-1:0]               r_left;
    logic                           r_rd_vld;
    ntprp_pkg::t_entry              r_rd_data;
    logic                           r_found;
    logic [ntprp_pkg::RECORD_W-1:0] r_partner;
    logic                           r_o_valid;
    logic                           r_o_is_request;
    logic                           r_o_paired;
    logic [ntprp_pkg::RECORD_W-1:0] r_o_partner;

    ntprp_pkg::t_entry              n_cur;
    logic                           n_is_req;
    logic [IDX_W-1:0]               n_wr_next;
    logic [IDX_W-1:0]               n_addr_prev;
    logic                           n_rd_issue;
    logic                           n_dir_ok;
    logic                           n_match;

    // capture and normalize; IPv4 keeps only the low 32 bits of the lo words
    always_comb begin
        n_is_req        = (i_udp_dst == r_server_port);
        n_cur.ipv6      = i_is_ipv6;
        n_cur.src_hi    = i_is_ipv6 ? i_src_addr_hi : '0;
        n_cur.dst_hi    = i_is_ipv6 ? i_dst_addr_hi : '0;
        n_cur.src_lo    = i_is_ipv6 ? i_src_addr_lo
                        : {{(ntprp_pkg::ADDR_W - ntprp_pkg::V4_W){1'b0}},
                           i_src_addr_lo[ntprp_pkg::V4_W-1:0]};
        n_cur.dst_lo    = i_is_ipv6 ? i_dst_addr_lo
                        : {{(ntprp_pkg::ADDR_W - ntprp_pkg::V4_W){1'b0}},
                           i_dst_addr_lo[ntprp_pkg::V4_W-1:0]};
        n_cur.udp_src   = i_udp_src;
        n_cur.udp_dst   = i_udp_dst;
        n_cur.key       = n_is_req ? i_transmit_stamp : i_originate_stamp;
        n_cur.record    = i_record_id;
    end

    assign n_wr_next   = (r_wr_idx == IDX_LAST) ? '0 : r_wr_idx + 1'b1;
    assign n_addr_prev = (r_addr == '0) ? IDX_LAST : r_addr - 1'b1;
    assign n_rd_issue  = i_cmd.scan && (r_left != '0);

    always_comb begin
        n_dir_ok = r_is_req ? (r_rd_data.udp_src == r_server_port)
                            : (r_rd_data.udp_dst == r_server_port);
        n_match  = n_dir_ok
                && (r_rd_data.ipv6   == r_cur.ipv6)
                && (r_rd_data.src_hi == r_cur.dst_hi)
                && (r_rd_data.src_lo == r_cur.dst_lo)
                && (r_rd_data.dst_hi == r_cur.src_hi)
                && (r_rd_data.dst_lo == r_cur.src_lo)
                && (r_rd_data.key    == r_cur.key);
    end

    assign o_status.hit      = i_cmd.scan && r_rd_vld && n_match;
    assign o_status.miss     = i_cmd.scan && !r_rd_vld && (r_left == '0);
    assign o_status.out_free = !r_o_valid || !i_out_stall;

    // ring memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[n_wr_next] <= r_cur;
        end
        if (n_rd_issue) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur    <= n_cur;
            r_is_req <= n_is_req;
            r_addr   <= r_wr_idx;
        end else if (n_rd_issue) begin
            r_addr   <= n_addr_prev;
        end
        if (i_cmd.scan && o_status.hit) begin
            r_partner <= r_rd_data.record;
        end else if (i_cmd.load) begin
            r_partner <= '0;
        end
        if (i_cmd.finish) begin
            r_o_is_request <= r_is_req;
            r_o_paired     <= r_found;
            r_o_partner    <= r_partner;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server_port <= ntprp_pkg::SERVER_PORT_RST;
            r_wr_idx      <= '0;
            r_fill        <= '0;
            r_left        <= '0;
            r_rd_vld      <= 1'b0;
            r_found       <= 1'b0;
            r_o_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_server_port <= i_cfg_data;
            end
            if (i_cmd.store) begin
                r_wr_idx <= n_wr_next;
                if (r_fill != CNT_FULL) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (i_cmd.load) begin
                r_left   <= r_fill;
                r_rd_vld <= 1'b0;
                r_found  <= 1'b0;
            end else begin
                if (n_rd_issue) begin
                    r_left <= r_left - 1'b1;
                end
                r_rd_vld <= n_rd_issue;
                if (o_status.hit) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid         = r_o_valid;
    assign o_is_request        = r_o_is_request;
    assign o_paired            = r_o_paired;
    assign o_partner_record_id = r_o_partner;

endmodule

FILE: hw/rtl/ntp_request_response_pairing_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntp_request_response_pairing_unit
// Pairs NTP requests with replies through a backward scan of a packet ring.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------------
//   input    | i_in_valid / o_in_stall   | i_is_ipv6 .. i_record_id
//   output   | o_out_valid / i_out_stall | o_is_request, o_paired, o_partner_*
//   config   | i_cfg_we                  | i_cfg_data (server port)
//
// A word scans up to fill ring entries, newest first, and stops at the first hit
// (fill = stored entries, at most RING_DEPTH): one ring entry is read per
// cycle on the single read port, so a full ring means up to RING_DEPTH reads
// per word.
// Synchronous reset clears the fill count, write pointer and result valid
// flag and sets the server port to 123; ring contents are not cleared.
// The next word is accepted while a result waits under i_out_stall; the
// unit holds in its hand-off step only if a second result is ready.
// ----------------------------------------------------------------------------
module ntp_request_response_pairing_unit #(
    parameter int RING_DEPTH = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ntprp_pkg::PORT_W-1:0]   i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_is_ipv6,
    input  logic [ntprp_pkg::ADDR_W-1:0]   i_src_addr_hi,
    input  logic [ntprp_pkg::ADDR_W-1:0]   i_src_addr_lo,
    input  logic [ntprp_pkg::ADDR_W-1:0]   i_dst_addr_hi,
    input  logic [ntprp_pkg::ADDR_W-1:0]   i_dst_addr_lo,
    input  logic [ntprp_pkg::PORT_W-1:0]   i_udp_src,
    input  logic [ntprp_pkg::PORT_W-1:0]   i_udp_dst,
    input  logic [ntprp_pkg::STAMP_W-1:0]  i_transmit_stamp,
    input  logic [ntprp_pkg::STAMP_W-1:0]  i_originate_stamp,
    input  logic [ntprp_pkg::RECORD_W-1:0] i_record_id,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_is_request,
    output logic                           o_paired,
    output logic [ntprp_pkg::RECORD_W-1:0] o_partner_record_id
);

    ntprp_pkg::t_cmd    w_cmd;
    ntprp_pkg::t_status w_status;

    ntprp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    ntprp_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data),
        .i_is_ipv6           (i_is_ipv6),
        .i_src_addr_hi       (i_src_addr_hi),
        .i_src_addr_lo       (i_src_addr_lo),
        .i_dst_addr_hi       (i_dst_addr_hi),
        .i_dst_addr_lo       (i_dst_addr_lo),
        .i_udp_src           (i_udp_src),
        .i_udp_dst           (i_udp_dst),
        .i_transmit_stamp    (i_transmit_stamp),
        .i_originate_stamp   (i_originate_stamp),
        .i_record_id         (i_record_id),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_is_request        (o_is_request),
        .o_paired            (o_paired),
        .o_partner_record_id (o_partner_record_id)
    );

endmodule
